// File: hdl/kcl_pkg.sv
// Package for the keypad code lock: sizes, key and event codes, lock modes
// and the result record passed from the core to the output stage.
// No dependencies.
package kcl_pkg;

    localparam int CODE_LENGTH = 6;
    localparam int FILL_W      = $clog2(CODE_LENGTH + 1);
    localparam int IDX_W       = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

    localparam logic [2:0] MAX_TRIES_RESET = 3'd3;

    localparam logic [3:0] KEY_DIGIT_MAX = 4'd9;
    localparam logic [3:0] KEY_CANCEL    = 4'd10;
    localparam logic [3:0] KEY_BACK      = 4'd11;
    localparam logic [3:0] KEY_CHANGE    = 4'd12;
    localparam logic [3:0] KEY_CONFIRM   = 4'd13;

    localparam logic [2:0] MODE_CODE_ENTER  = 3'd0;
    localparam logic [2:0] MODE_CODE_OPEN   = 3'd1;
    localparam logic [2:0] MODE_CODE_NEW    = 3'd2;
    localparam logic [2:0] MODE_CODE_REPEAT = 3'd3;
    localparam logic [2:0] MODE_CODE_LOCKED = 3'd4;

    typedef enum logic [4:0] {
        MODE_ENTER  = 5'b00001,
        MODE_OPEN   = 5'b00010,
        MODE_NEW    = 5'b00100,
        MODE_REPEAT = 5'b01000,
        MODE_LOCKED = 5'b10000
    } mode_t;

    typedef enum logic [3:0] {
        EV_IGNORED        = 4'd0,
        EV_DIGIT          = 4'd1,
        EV_FULL           = 4'd2,
        EV_CLEARED        = 4'd3,
        EV_BACKSPACE      = 4'd4,
        EV_TOO_SHORT      = 4'd5,
        EV_WRONG          = 4'd6,
        EV_OPENED         = 4'd7,
        EV_NEW_STORED     = 4'd8,
        EV_MISMATCH       = 4'd9,
        EV_CHANGE_DONE    = 4'd10,
        EV_LOCKED         = 4'd11,
        EV_CHANGE_STARTED = 4'd12
    } event_t;

    typedef struct packed {
        event_t     ev;
        logic [2:0] entered;
        logic [2:0] failures;
        logic [2:0] mode_now;
        logic       alarm;
    } kcl_result_t;

endpackage

// File: hdl/kcl_core.sv
// Lock core: mode, entry buffer, stored code and try counter, with the
// per-key next-state logic and the result record for that key.
// Depends on kcl_pkg.
module kcl_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [3:0]          key,
    input  logic [2:0]          max_tries,
    output kcl_pkg::kcl_result_t result
);
    import kcl_pkg::*;

    mode_t                           mode_reg,    mode_next;
    logic [FILL_W-1:0]               fill_reg,    fill_next;
    logic [CODE_LENGTH-1:0][3:0]     entry_reg,   entry_next;
    logic [CODE_LENGTH-1:0][3:0]     stored_reg,  stored_next;
    logic [2:0]                      tries_reg,   tries_next;
    event_t                          ev;
    logic                            full;
    logic                            match;

    assign full  = (fill_reg == FILL_W'(CODE_LENGTH));
    assign match = (entry_reg == stored_reg);

    always_comb
    begin
        mode_next   = mode_reg;
        fill_next   = fill_reg;
        entry_next  = entry_reg;
        stored_next = stored_reg;
        tries_next  = tries_reg;
        ev          = EV_IGNORED;
        case (mode_reg)
            MODE_OPEN:
            begin
                if (key == KEY_CHANGE)
                begin
                    mode_next  = MODE_NEW;
                    fill_next  = '0;
                    tries_next = max_tries;
                    ev         = EV_CHANGE_STARTED;
                end
            end
            MODE_ENTER, MODE_NEW, MODE_REPEAT:
            begin
                if (key inside {[4'd0:KEY_DIGIT_MAX]})
                begin
                    if (!full)
                    begin
                        entry_next[fill_reg[IDX_W-1:0]] = key;
                        fill_next = fill_reg + FILL_W'(1);
                        ev        = EV_DIGIT;
                    end
                    else
                    begin
                        ev = EV_FULL;
                    end
                end
                else if (key == KEY_CANCEL)
                begin
                    if (fill_reg != '0)
                    begin
                        fill_next = '0;
                        ev        = EV_CLEARED;
                    end
                end
                else if (key == KEY_BACK)
                begin
                    if (fill_reg != '0)
                    begin
                        fill_next = fill_reg - FILL_W'(1);
                        ev        = EV_BACKSPACE;
                    end
                end
                else if (key == KEY_CONFIRM)
                begin
                    if (!full)
                    begin
                        ev = EV_TOO_SHORT;
                    end
                    else
                    begin
                        fill_next = '0;
                        if (mode_reg == MODE_ENTER)
                        begin
                            if (match)
                            begin
                                mode_next  = MODE_OPEN;
                                tries_next = max_tries;
                                ev         = EV_OPENED;
                            end
                            else if (tries_reg <= 3'd1)
                            begin
                                // last try gone: lock for good
                                tries_next = '0;
                                mode_next  = MODE_LOCKED;
                                ev         = EV_LOCKED;
                            end
                            else
                            begin
                                tries_next = tries_reg - 3'd1;
                                ev         = EV_WRONG;
                            end
                        end
                        else if (mode_reg == MODE_NEW)
                        begin
                            stored_next = entry_reg;
                            mode_next   = MODE_REPEAT;
                            ev          = EV_NEW_STORED;
                        end
                        else if (match)
                        begin
                            mode_next  = MODE_ENTER;
                            tries_next = max_tries;
                            ev         = EV_CHANGE_DONE;
                        end
                        else
                        begin
                            ev = EV_MISMATCH;
                        end
                    end
                end
            end
            default:
            begin
                ev = EV_IGNORED;
            end
        endcase
    end

    always_comb
    begin
        result.ev       = ev;
        result.entered  = 3'(fill_next);
        result.failures = (tries_next > max_tries) ? 3'd0 : (max_tries - tries_next);
        result.alarm    = (mode_next == MODE_LOCKED);
        case (mode_next)
            MODE_ENTER:  result.mode_now = MODE_CODE_ENTER;
            MODE_OPEN:   result.mode_now = MODE_CODE_OPEN;
            MODE_NEW:    result.mode_now = MODE_CODE_NEW;
            MODE_REPEAT: result.mode_now = MODE_CODE_REPEAT;
            MODE_LOCKED: result.mode_now = MODE_CODE_LOCKED;
            default:     result.mode_now = MODE_CODE_ENTER;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_ENTER;
            fill_reg   <= '0;
            stored_reg <= '0;
            tries_reg  <= MAX_TRIES_RESET;
        end
        else if (step)
        begin
            mode_reg   <= mode_next;
            fill_reg   <= fill_next;
            stored_reg <= stored_next;
            tries_reg  <= tries_next;
        end
    end

    // entry digits are only read once written
    always_ff @(posedge clk)
    begin
        if (step)
        begin
            entry_reg <= entry_next;
        end
    end

endmodule

// File: hdl/keypad_code_lock_unit.sv
// Keypad code lock, top level: key input register, lock core, result register
// and the max_tries configuration register. Depends on kcl_pkg and kcl_core.
// A key taken into the key register goes through the core into the result
// register once that slot is free. Throughput: one key per cycle while
// out_ready drains the result register (combinational core update); a waiting
// result holds the next key off only once the key register is also full.
// Reset (rst_n low, asynchronous): enter mode, empty buffer, code all zeros,
// max_tries and tries left at 3, no key or result beat pending.
module keypad_code_lock_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] key_code,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [3:0] event_res,
    output logic [2:0] entered_count,
    output logic [2:0] failures,
    output logic [2:0] mode_now,
    output logic       alarm,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] max_tries
);
    import kcl_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [3:0]  key_reg;
    logic        out_valid_reg, out_valid_next;
    kcl_result_t out_reg;
    kcl_result_t core_result;
    logic [2:0]  max_tries_reg;
    logic        advance;

    // move the held key through the core when the result slot frees up
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_valid && in_ready)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;

        out_valid_next = out_valid_reg;
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            max_tries_reg <= MAX_TRIES_RESET;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
                max_tries_reg <= max_tries;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            key_reg <= key_code;
        if (advance)
            out_reg <= core_result;
    end

    kcl_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (advance),
        .key       (key_reg),
        .max_tries (max_tries_reg),
        .result    (core_result)
    );

    assign out_valid     = out_valid_reg;
    assign event_res     = out_reg.ev;
    assign entered_count = out_reg.entered;
    assign failures      = out_reg.failures;
    assign mode_now      = out_reg.mode_now;
    assign alarm         = out_reg.alarm;

`ifndef NO_ASSERTIONS
    a_key_held_on_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && !out_ready) |=> (in_valid_reg && $stable(key_reg)))
        else $error("held key lost while result stalled");

    a_alarm_mode: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_reg.alarm == (out_reg.mode_now == MODE_CODE_LOCKED)))
        else $error("alarm does not match locked mode");

    a_opened_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.ev == EV_OPENED) |->
            (out_reg.mode_now == MODE_CODE_OPEN && out_reg.entered == 3'd0))
        else $error("open event without empty buffer in open mode");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (32'(out_reg.entered) <= CODE_LENGTH))
        else $error("entry count beyond code length");
`endif

endmodule
